// File: hdl/plf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_pkg: shared types and helpers for the particle leapfrog integrator
// Fixed-point widths, mode codes, queue item layout and saturation helpers.
// ----------------------------------------------------------------------------
package plf_pkg;

    localparam int PARTICLES_DEF = 1024;
    localparam int FIX_W         = 32;
    localparam int IDX_W         = 10;
    localparam int DT_W          = 16;
    localparam int NUM_W         = 48;
    localparam logic [DT_W-1:0] TIME_STEP_RST = 16'd655;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FORCE = 2'd1,
        MODE_INTEG = 2'd2,
        MODE_VEL   = 2'd3
    } mode_t;

    typedef logic [2:0][FIX_W-1:0] vec3_t;

    typedef struct packed {
        mode_t             mode;
        logic [IDX_W-1:0]  particle;
        vec3_t             vec;
        vec3_t             load_vel;
        logic [FIX_W-1:0]  density;
    } plf_item_t;

    typedef struct packed {
        logic take;
        logic clearing;
    } plf_back_st_t;

    function automatic logic [FIX_W-1:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -50'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    // signed quotient from magnitude and sign, clamped to 32 bits
    function automatic logic [FIX_W-1:0] quo_sat(input logic [NUM_W-1:0] q, input logic neg);
        if (neg)
            return (q > 48'd2147483648) ? 32'h8000_0000 : 32'(-q);
        else
            return (q > 48'd2147483647) ? 32'h7fff_ffff : q[31:0];
    endfunction

endpackage

// File: hdl/plf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_front: input acceptance and decoupling queue
// Drops items with an out-of-range particle index, queues the rest.
// ----------------------------------------------------------------------------
module plf_front #(
    parameter int PARTICLES = plf_pkg::PARTICLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  plf_pkg::plf_item_t    in_item,
    input  plf_pkg::plf_back_st_t back_st,
    output logic                  q_valid,
    output plf_pkg::plf_item_t    q_item
);
    import plf_pkg::*;

    plf_item_t  q_mem_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       in_range, enq, deq;

    assign in_range = {7'd0, in_item.particle} < 17'(PARTICLES);
    assign full     = back_st.clearing || (cnt_reg == 2'd2);
    assign enq      = push && !full && in_range;
    assign deq      = back_st.take;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ deq;
        wr_ptr_next = wr_ptr_reg ^ enq;
        cnt_next    = cnt_reg + 2'(enq) - 2'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            q_mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// File: hdl/plf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, 48-bit dividend.
// ----------------------------------------------------------------------------
module plf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [plf_pkg::NUM_W-1:0]  num,
    input  logic [plf_pkg::FIX_W-1:0]  den,
    output logic                       done,
    output logic [plf_pkg::NUM_W-1:0]  quo
);
    import plf_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [FIX_W-1:0] rem_reg;
    logic [FIX_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg, done_reg;
    logic [FIX_W:0]   sh;
    logic             ge;

    assign sh   = {rem_reg, num_reg[NUM_W-1]};
    assign ge   = sh >= {1'b0, den_reg};
    assign done = done_reg;
    assign quo  = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(NUM_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? FIX_W'(sh - {1'b0, den_reg}) : sh[FIX_W-1:0];
        end
    end

endmodule

// File: hdl/plf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_back: particle store and update sequencer
// Reads a particle row, applies the mode, writes it back and posts a result.
// ----------------------------------------------------------------------------
module plf_back #(
    parameter int PARTICLES = plf_pkg::PARTICLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  plf_pkg::plf_item_t         q_item,
    output plf_pkg::plf_back_st_t      back_st,
    input  logic [plf_pkg::DT_W-1:0]   time_step,
    input  logic                       pop,
    output logic                       empty,
    output logic [plf_pkg::IDX_W-1:0]  res_particle,
    output plf_pkg::vec3_t             res_pos,
    output plf_pkg::vec3_t             res_half,
    output plf_pkg::vec3_t             res_vel
);
    import plf_pkg::*;

    localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_READ  = 10'b0000000100,
        S_DATA  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_MUL1  = 10'b0000100000,
        S_HALF  = 10'b0001000000,
        S_MUL2  = 10'b0010000000,
        S_POS   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t  state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic    out_valid_reg, out_valid_next;

    vec3_t pos_mem   [PARTICLES];
    vec3_t half_mem  [PARTICLES];
    vec3_t old_mem   [PARTICLES];
    vec3_t vel_mem   [PARTICLES];
    vec3_t force_mem [PARTICLES];
    logic  flag_mem  [PARTICLES];

    plf_item_t item_reg;
    vec3_t pos_rd_reg, half_rd_reg, old_rd_reg, vel_rd_reg, force_rd_reg;
    logic  flag_rd_reg;
    vec3_t wpos_reg, whalf_reg, wold_reg, wvel_reg, wforce_reg;
    logic  wflag_reg;
    vec3_t acc_reg;
    logic signed [48:0] prod_a_reg [3];
    logic signed [48:0] prod_b_reg [3];

    logic [AW-1:0]    addr, wr_addr;
    logic             clearing, out_free, mem_we, div_start;
    logic [2:0]       div_done;
    logic [NUM_W-1:0] div_num [3];
    logic [NUM_W-1:0] div_quo [3];
    logic [FIX_W-1:0] mag [3];
    logic [FIX_W-1:0] hb [3];
    logic [FIX_W-1:0] hn [3];
    logic signed [32:0] vsum [3];

    assign clearing  = (state_reg == S_CLEAR);
    assign out_free  = !out_valid_reg || pop;
    assign addr      = AW'(item_reg.particle);
    assign wr_addr   = clearing ? clr_cnt_reg : addr;
    assign mem_we    = clearing || ((state_reg == S_DONE) && out_free);
    assign div_start = (state_reg == S_DATA) && (item_reg.mode == MODE_INTEG);
    assign empty     = !out_valid_reg;
    assign back_st   = '{take: (state_reg == S_IDLE) && q_valid, clearing: clearing};

    // lane datapath: divider operands, first-step and half-step velocity
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mag[c]     = force_rd_reg[c][31] ? 32'(-force_rd_reg[c]) : force_rd_reg[c];
            div_num[c] = {mag[c], 16'd0};
            hb[c]      = flag_rd_reg
                       ? sat32(50'($signed(vel_rd_reg[c])) - 50'(prod_a_reg[c] >>> 17))
                       : half_rd_reg[c];
            hn[c]      = sat32(50'($signed(hb[c])) + 50'(prod_a_reg[c] >>> 16));
            vsum[c]    = 33'($signed(old_rd_reg[c])) + 33'($signed(half_rd_reg[c]));
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        plf_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (div_num[g]),
            .den   (item_reg.density),
            .done  (div_done[g]),
            .quo   (div_quo[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(PARTICLES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:  if (q_valid) state_next = S_READ;
            S_READ:  state_next = S_DATA;
            S_DATA:  state_next = (item_reg.mode == MODE_INTEG) ? S_DIV : S_DONE;
            S_DIV:   if (div_done[0]) state_next = S_MUL1;
            S_MUL1:  state_next = S_HALF;
            S_HALF:  state_next = S_MUL2;
            S_MUL2:  state_next = S_POS;
            S_POS:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // particle stores: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[wr_addr]   <= clearing ? '0 : wpos_reg;
            half_mem[wr_addr]  <= clearing ? '0 : whalf_reg;
            old_mem[wr_addr]   <= clearing ? '0 : wold_reg;
            vel_mem[wr_addr]   <= clearing ? '0 : wvel_reg;
            force_mem[wr_addr] <= clearing ? '0 : wforce_reg;
            flag_mem[wr_addr]  <= clearing ? 1'b1 : wflag_reg;
        end
        if (state_reg == S_READ)
        begin
            pos_rd_reg   <= pos_mem[addr];
            half_rd_reg  <= half_mem[addr];
            old_rd_reg   <= old_mem[addr];
            vel_rd_reg   <= vel_mem[addr];
            force_rd_reg <= force_mem[addr];
            flag_rd_reg  <= flag_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_st.take)
            item_reg <= q_item;
        if (state_reg == S_DATA)
        begin
            unique case (item_reg.mode)
                MODE_LOAD:
                begin
                    wpos_reg   <= item_reg.vec;
                    whalf_reg  <= half_rd_reg;
                    wold_reg   <= old_rd_reg;
                    wvel_reg   <= item_reg.load_vel;
                    wforce_reg <= '0;
                    wflag_reg  <= 1'b1;
                end
                MODE_FORCE:
                begin
                    wpos_reg   <= pos_rd_reg;
                    whalf_reg  <= half_rd_reg;
                    wold_reg   <= old_rd_reg;
                    wvel_reg   <= vel_rd_reg;
                    wflag_reg  <= flag_rd_reg;
                    for (int c = 0; c < 3; c++)
                        wforce_reg[c] <= sat32(50'($signed(force_rd_reg[c]))
                                             + 50'($signed(item_reg.vec[c])));
                end
                MODE_INTEG:
                begin
                    wpos_reg   <= pos_rd_reg;
                    whalf_reg  <= half_rd_reg;
                    wold_reg   <= old_rd_reg;
                    wvel_reg   <= vel_rd_reg;
                    wforce_reg <= '0;
                    wflag_reg  <= 1'b0;
                end
                MODE_VEL:
                begin
                    wpos_reg   <= pos_rd_reg;
                    whalf_reg  <= half_rd_reg;
                    wold_reg   <= old_rd_reg;
                    wforce_reg <= force_rd_reg;
                    wflag_reg  <= flag_rd_reg;
                    for (int c = 0; c < 3; c++)
                        wvel_reg[c] <= vsum[c][32:1];
                end
            endcase
        end
        if ((state_reg == S_DIV) && div_done[0])
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= (item_reg.density == '0) ? '0
                            : quo_sat(div_quo[c], force_rd_reg[c][31]);
        end
        if (state_reg == S_MUL1)
        begin
            for (int c = 0; c < 3; c++)
                prod_a_reg[c] <= $signed(acc_reg[c]) * $signed({1'b0, time_step});
        end
        if (state_reg == S_HALF)
        begin
            for (int c = 0; c < 3; c++)
            begin
                wold_reg[c]  <= hb[c];
                whalf_reg[c] <= hn[c];
            end
        end
        if (state_reg == S_MUL2)
        begin
            for (int c = 0; c < 3; c++)
                prod_b_reg[c] <= $signed(whalf_reg[c]) * $signed({1'b0, time_step});
        end
        if (state_reg == S_POS)
        begin
            for (int c = 0; c < 3; c++)
                wpos_reg[c] <= sat32(50'($signed(pos_rd_reg[c])) + 50'(prod_b_reg[c] >>> 16));
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            res_particle <= item_reg.particle;
            res_pos      <= wpos_reg;
            res_half     <= whalf_reg;
            res_vel      <= wvel_reg;
        end
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.take |-> !clearing && (state_reg == S_IDLE))
        else $error("item taken outside idle");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_done[0] == div_done[1]) && (div_done[0] == div_done[2]))
        else $error("divider lanes out of step");

    a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && out_free |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished item not posted");

endmodule

// File: hdl/particle_leapfrog_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_leapfrog_integrator_unit: leapfrog particle integrator, Q16.16
// Keeps per-particle position, velocities and force sums; loads, adds
// forces, integrates one step or averages the half-step velocities.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        mode, particle, vec_*, load_vel_*, density
//  result    pop / empty        out_particle, pos_*, half_vel_*, vel_*
//  config    cfg_we             cfg_wdata (time_step)
//
//  load, add force, approximate velocity: read, data and done states only
//  integrate: adds divide, multiply, half-step and position states; 48-step iterative divider per lane
//  after reset a clearing pass over all PARTICLES entries runs; full stays high
//  a two-entry queue separates acceptance from the update sequencer
//  a waiting result stalls only the write-back, the queue keeps filling
// ----------------------------------------------------------------------------
module particle_leapfrog_integrator_unit #(
    parameter int PARTICLES = plf_pkg::PARTICLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [9:0]  particle,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [31:0] load_vel_x,
    input  logic signed [31:0] load_vel_y,
    input  logic signed [31:0] load_vel_z,
    input  logic [31:0] density,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  out_particle,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] half_vel_x,
    output logic signed [31:0] half_vel_y,
    output logic signed [31:0] half_vel_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import plf_pkg::*;

    // time step register, unsigned q0.16
    logic [DT_W-1:0] time_step_reg;
    plf_item_t       in_item, q_item;
    plf_back_st_t    back_st;
    logic            q_valid;
    vec3_t           res_pos, res_half, res_vel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TIME_STEP_RST;
        else if (cfg_we)
            time_step_reg <= cfg_wdata;
    end

    // pack the input transaction, lane 0 is x
    always_comb
    begin
        in_item.mode     = mode_t'(mode);
        in_item.particle = particle;
        in_item.vec      = {vec_z, vec_y, vec_x};
        in_item.load_vel = {load_vel_z, load_vel_y, load_vel_x};
        in_item.density  = density;
    end

    // front: range check and decoupling queue
    plf_front #(.PARTICLES(PARTICLES)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .back_st (back_st),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // back: store access, arithmetic and result register
    plf_back #(.PARTICLES(PARTICLES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .back_st      (back_st),
        .time_step    (time_step_reg),
        .pop          (pop),
        .empty        (empty),
        .res_particle (out_particle),
        .res_pos      (res_pos),
        .res_half     (res_half),
        .res_vel      (res_vel)
    );

    assign pos_x      = res_pos[0];
    assign pos_y      = res_pos[1];
    assign pos_z      = res_pos[2];
    assign half_vel_x = res_half[0];
    assign half_vel_y = res_half[1];
    assign half_vel_z = res_half[2];
    assign vel_x      = res_vel[0];
    assign vel_y      = res_vel[1];
    assign vel_z      = res_vel[2];

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: particle leapfrog integrator unit
// Drives load, add force, integrate and approximate velocity transactions,
// predicts every result with a fixed-point model of the particle table and
// compares each popped result field by field, under random idling on both
// sides, several time steps and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import plf_pkg::*;

    typedef struct {
        mode_t             op;
        logic [9:0]        idx;
        logic signed [31:0] vec [3];
        logic signed [31:0] lvel [3];
        logic [31:0]       dens;
    } cmd_t;

    typedef struct {
        logic [9:0]        idx;
        logic signed [31:0] pos [3];
        logic signed [31:0] hvel [3];
        logic signed [31:0] vel [3];
    } state_t;

    // particle table model and queue of expected particle states
    class particle_scoreboard;
        int     pos_mem [3072];
        int     half_mem [3072];
        int     old_mem [3072];
        int     vel_mem [3072];
        int     force_mem [3072];
        bit     first_step [1024];
        longint dt;
        state_t expected_states [$];
        int     mismatches;
        int     checked;
        int     noted;

        function new();
            foreach (first_step[i])
                first_step[i] = 1'b1;
            dt = TIME_STEP_RST;
        endfunction

        function int clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'h7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return int'(v);
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // update the table for one accepted transaction and queue its result
        function void note_input(cmd_t c);
            int     k;
            longint acc;
            longint h;
            state_t s;
            noted++;
            for (int j = 0; j < 3; j++) begin
                k = c.idx * 3 + j;
                case (c.op)
                    MODE_LOAD:
                    begin
                        pos_mem[k] = c.vec[j];
                        vel_mem[k] = c.lvel[j];
                        force_mem[k] = 0;
                    end
                    MODE_FORCE:
                        force_mem[k] = clamp(longint'(force_mem[k]) + longint'(c.vec[j]));
                    MODE_INTEG:
                    begin
                        acc = 0;
                        if (c.dens != 0)
                            acc = clamp((longint'(force_mem[k]) <<< 16)
                                        / longint'(c.dens));
                        if (first_step[c.idx])
                            half_mem[k] = clamp(longint'(vel_mem[k]) - ((acc * dt) >>> 17));
                        old_mem[k] = half_mem[k];
                        h = clamp(longint'(half_mem[k]) + ((acc * dt) >>> 16));
                        half_mem[k] = int'(h);
                        pos_mem[k] = clamp(longint'(pos_mem[k]) + ((h * dt) >>> 16));
                        force_mem[k] = 0;
                    end
                    default:
                        vel_mem[k] = clamp((longint'(old_mem[k]) + longint'(half_mem[k])) >>> 1);
                endcase
            end
            if (c.op == MODE_LOAD)
                first_step[c.idx] = 1'b1;
            else if (c.op == MODE_INTEG)
                first_step[c.idx] = 1'b0;
            s.idx = c.idx;
            for (int j = 0; j < 3; j++) begin
                k = c.idx * 3 + j;
                s.pos[j] = pos_mem[k];
                s.hvel[j] = half_mem[k];
                s.vel[j] = vel_mem[k];
            end
            expected_states.push_back(s);
        endfunction

        task check(state_t got);
            state_t e;
            checked++;
            if (expected_states.size() == 0) begin
                report($sformatf("result for particle %0d with nothing expected", got.idx));
                return;
            end
            e = expected_states.pop_front();
            if (got.idx !== e.idx)
                report($sformatf("out_particle %0d, expected %0d", got.idx, e.idx));
            for (int j = 0; j < 3; j++) begin
                if (got.pos[j] !== e.pos[j])
                    report($sformatf("p%0d pos[%0d] %h, expected %h",
                                     e.idx, j, got.pos[j], e.pos[j]));
                if (got.hvel[j] !== e.hvel[j])
                    report($sformatf("p%0d half_vel[%0d] %h, expected %h",
                                     e.idx, j, got.hvel[j], e.hvel[j]));
                if (got.vel[j] !== e.vel[j])
                    report($sformatf("p%0d vel[%0d] %h, expected %h",
                                     e.idx, j, got.vel[j], e.vel[j]));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  mode;
    logic [9:0]  particle;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic signed [31:0] load_vel_x, load_vel_y, load_vel_z;
    logic [31:0] density;
    logic        empty;
    logic        pop;
    logic [9:0]  out_particle;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] half_vel_x, half_vel_y, half_vel_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    particle_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;
    int op_count [4];

    particle_leapfrog_integrator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .particle     (particle),
        .vec_x        (vec_x),
        .vec_y        (vec_y),
        .vec_z        (vec_z),
        .load_vel_x   (load_vel_x),
        .load_vel_y   (load_vel_y),
        .load_vel_z   (load_vel_z),
        .density      (density),
        .empty        (empty),
        .pop          (pop),
        .out_particle (out_particle),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .half_vel_x   (half_vel_x),
        .half_vel_y   (half_vel_y),
        .half_vel_z   (half_vel_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well past the slowest legal run, clearing pass included
    initial
    begin
        #60ms;
        $display("timeout waiting for results");
        $display("CHECKS FAILED");
        $finish;
    end

    // random 32-bit value, biased toward the extremes now and then
    function logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] rand_density();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom_range(1, 255);
            3: return $urandom;
            default: return $urandom_range(32'h0000_8000, 32'h0010_0000);
        endcase
    endfunction

    function cmd_t make_cmd(mode_t op, logic [9:0] idx);
        cmd_t c;
        c.op = op;
        c.idx = idx;
        for (int j = 0; j < 3; j++) begin
            c.vec[j] = rand_word();
            c.lvel[j] = rand_word();
        end
        c.dens = rand_density();
        return c;
    endfunction

    // present one transaction and hold it until the block takes it;
    // push stays high on return so back-to-back transactions need no gap
    task send(cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        mode       <= c.op;
        particle   <= c.idx;
        vec_x      <= c.vec[0];
        vec_y      <= c.vec[1];
        vec_z      <= c.vec[2];
        load_vel_x <= c.lvel[0];
        load_vel_y <= c.lvel[1];
        load_vel_z <= c.lvel[2];
        density    <= c.dens;
        do
            @(posedge clk);
        while (full);
        sb.note_input(c);
        op_count[c.op]++;
    endtask

    task send_op(mode_t op, logic [9:0] idx);
        send(make_cmd(op, idx));
    endtask

    // one well-formed step: optional load, zero to four forces, integrate, optional velocity update
    task send_step_sequence();
        logic [9:0] idx;
        idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0)
            send_op(MODE_LOAD, idx);
        repeat ($urandom_range(0, 4))
            send_op(MODE_FORCE, idx);
        send_op(MODE_INTEG, idx);
        if ($urandom_range(0, 3) != 0)
            send_op(MODE_VEL, idx);
        // stray transaction to keep the ordering honest
        if ($urandom_range(0, 5) == 0)
            send_op(mode_t'($urandom_range(0, 3)), 10'($urandom));
    endtask

    task run_random(int n);
        int start;
        start = sb.noted;
        while (sb.noted - start < n)
            send_step_sequence();
    endtask

    // drain the block, let the write-back settle, then change the time step
    task set_time_step(logic [15:0] v);
        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_states.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.dt = v;
    endtask

    // result side: random pop idling plus an optional long hold-off
    initial
    begin
        state_t got;
        pop <= 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(posedge clk);
            if (pop && !empty) begin
                got.idx = out_particle;
                got.pos[0] = pos_x;
                got.pos[1] = pos_y;
                got.pos[2] = pos_z;
                got.hvel[0] = half_vel_x;
                got.hvel[1] = half_vel_y;
                got.hvel[2] = half_vel_z;
                got.vel[0] = vel_x;
                got.vel[1] = vel_y;
                got.vel[2] = vel_z;
                sb.check(got);
            end
        end
    end

    initial
    begin
        cmd_t c;
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        rst_n      <= 1'b0;
        push       <= 1'b0;
        mode       <= MODE_LOAD;
        particle   <= '0;
        vec_x      <= '0;
        vec_y      <= '0;
        vec_z      <= '0;
        load_vel_x <= '0;
        load_vel_y <= '0;
        load_vel_z <= '0;
        density    <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset time step, extremes, saturation, zero density
        c = make_cmd(MODE_LOAD, 10'd0);
        c.vec = '{32'h7fff_ffff, 32'h8000_0000, 32'h0};
        c.lvel = '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
        send(c);
        c.op = MODE_FORCE;
        c.vec = '{32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000};
        send(c);
        send(c);                                    // force sum saturates
        c.op = MODE_INTEG;
        c.dens = 32'd0;                             // no acceleration
        send(c);
        send_op(MODE_VEL, 10'd0);
        c = make_cmd(MODE_FORCE, 10'd0);
        c.vec = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000};
        send(c);
        c.op = MODE_INTEG;
        c.dens = 32'd1;                             // acceleration clamps
        send(c);
        send_op(MODE_VEL, 10'd0);
        c = make_cmd(MODE_LOAD, 10'd1023);
        c.vec = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        c.lvel = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        send(c);
        c.op = MODE_FORCE;
        c.vec = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
        send(c);
        c.op = MODE_INTEG;
        c.dens = 32'hffff_ffff;
        send(c);
        send_op(MODE_INTEG, 10'd1023);              // second step, flag clear
        send_op(MODE_VEL, 10'd1023);
        send_op(MODE_VEL, 10'd512);                 // untouched particle
        send_op(MODE_INTEG, 10'd513);

        set_time_step(16'hffff);
        send_idle_pct = 12;
        recv_idle_pct = 73;
        run_random(450);

        set_time_step(16'h0000);
        send_idle_pct = 73;
        recv_idle_pct = 12;
        run_random(450);

        set_time_step(16'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // receiver holds off while the sender keeps pushing
        hold_req = 1'b1;
        run_random(60);
        run_random(450);

        set_time_step(TIME_STEP_RST);
        run_random(100);

        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_states.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d transactions: %0d load, %0d force, %0d integrate, %0d velocity",
                 sb.noted, op_count[MODE_LOAD], op_count[MODE_FORCE],
                 op_count[MODE_INTEG], op_count[MODE_VEL]);
        $display("%0d results checked over four time steps, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/plf_pkg.sv
hdl/plf_front.sv
hdl/plf_div.sv
hdl/plf_back.sv
hdl/particle_leapfrog_integrator_unit.sv
dv/testbench.sv
